### sv/keypad_expression_evaluator_defines.svh
// ----------------------------------------------------------------------------
// Keypad expression evaluator assertion macros
// Shared macros for the concurrent checks; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_EXPRESSION_EVALUATOR_DEFINES_SVH
`define KEYPAD_EXPRESSION_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define KEE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define KEE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define KEE_ASSERT(lbl, prop, msg)
`define KEE_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

### sv/kee_pkg.sv
// ----------------------------------------------------------------------------
// Keypad expression evaluator package
// Widths, limits, key codes and item types shared by the evaluator modules.
// ----------------------------------------------------------------------------
package kee_pkg;

    localparam int VALUE_BITS = 48;
    localparam int FRAC_BITS  = 16;
    localparam int DIV_W      = VALUE_BITS + FRAC_BITS;
    localparam int WIDE_W     = (2 * VALUE_BITS > DIV_W) ? 2 * VALUE_BITS : DIV_W;
    localparam int CNT_W      = $clog2(DIV_W + 1);
    localparam int OPCODE_W   = 3;
    localparam int DIGIT_W    = 4;

    localparam logic [VALUE_BITS-1:0] POS_LIM = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] NEG_LIM = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_DIGIT  = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_EQUALS = 3'd5,
        OP_CLEAR  = 3'd6
    } t_opcode;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [DIGIT_W-1:0]  digit;
    } t_key_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         div_by_zero;
        logic                         overflow;
    } t_result_item;

    typedef struct packed {
        logic                  is_div;
        logic [VALUE_BITS-1:0] a;
        logic [VALUE_BITS-1:0] b;
    } t_md_req;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] value;
        logic                  overflow;
        logic                  div_by_zero;
    } t_md_rsp;

endpackage

### sv/keypad_expression_evaluator.sv
// ----------------------------------------------------------------------------
// Keypad expression evaluator
// Four-function calculator with precedence, fed one key item at a time.
// ----------------------------------------------------------------------------
// Each input item is one key: a digit, add, subtract, multiply, divide, equals
// or clear. Multiply and divide bind tighter than add and subtract, and values
// are signed fixed point with 16 fraction bits in 48 bits, saturating on
// overflow. Only equals produces an output item; after it every key but clear
// is ignored. A digit, an ignored key, clear, or a multiply or divide key that
// closes no term is handled in the idle state; add, subtract or equals that closes
// no term also passes through the sum state. A key that closes a pending multiply
// or divide waits for the serial unit, which handles one multiplier or quotient bit
// per cycle; a zero divisor skips the bit steps. Keys are taken while an output
// item waits to be read, but an equals holds the input in the sum state until
// the previous output item has been read.
`include "keypad_expression_evaluator_defines.svh"

module keypad_expression_evaluator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  kee_pkg::t_key_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output kee_pkg::t_result_item o_out_data
);
    import kee_pkg::*;

    localparam int ENT_W = VALUE_BITS + 4;
    localparam logic [ENT_W-1:0] ENT_IMAX = ENT_W'(POS_LIM >> FRAC_BITS);
    localparam logic signed [VALUE_BITS+1:0] SUM_POS = {2'b00, POS_LIM};
    localparam logic signed [VALUE_BITS+1:0] SUM_NEG = {2'b11, NEG_LIM};

    typedef enum logic [1:0] {S_IDLE, S_MULDIV, S_SUM} t_state;
    typedef enum logic [1:0] {TOP_NONE, TOP_MUL, TOP_DIV} t_term_op;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  ovf;
    } t_sum;

    function automatic t_sum sat_add(input logic [VALUE_BITS-1:0] a,
                                     input logic [VALUE_BITS-1:0] p,
                                     input logic                  neg);
        logic signed [VALUE_BITS+1:0] ae;
        logic signed [VALUE_BITS+1:0] pe;
        logic signed [VALUE_BITS+1:0] s;
        t_sum                         res;
        ae = signed'({{2{a[VALUE_BITS-1]}}, a});
        pe = signed'({{2{p[VALUE_BITS-1]}}, p});
        if (neg) begin
            pe = -pe;
        end
        s = ae + pe;
        res.ovf = 1'b0;
        if (s > SUM_POS) begin
            res.value = POS_LIM;
            res.ovf   = 1'b1;
        end else if (s < SUM_NEG) begin
            res.value = NEG_LIM;
            res.ovf   = 1'b1;
        end else begin
            res.value = s[VALUE_BITS-1:0];
        end
        return res;
    endfunction

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_entry, n_entry;
    logic [VALUE_BITS-1:0] r_sum, n_sum;
    logic [VALUE_BITS-1:0] r_pending, n_pending;
    t_term_op              r_term_op, n_term_op;
    logic                  r_term_neg, n_term_neg;
    logic                  r_finished, n_finished;
    logic                  r_dbz, n_dbz;
    logic                  r_ovf, n_ovf;
    logic [OPCODE_W-1:0]   r_key_op, n_key_op;
    logic                  r_md_start, n_md_start;
    logic                  r_out_valid, n_out_valid;
    t_result_item          r_out_data, n_out_data;

    logic [ENT_W-1:0]      ent_int, ent_sum;
    logic                  ent_ovf;
    t_sum                  sum_res;
    t_md_req               md_req;
    t_md_rsp               md_rsp;
    logic                  key_is_term;
    t_term_op              key_term;

    kee_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_md_start),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    assign md_req.is_div = (r_term_op == TOP_DIV);
    assign md_req.a      = r_pending;
    assign md_req.b      = r_entry;

    assign ent_int = ENT_W'(r_entry >> FRAC_BITS);
    assign ent_sum = (ent_int << 3) + (ent_int << 1) + ENT_W'(i_in_data.digit);
    assign ent_ovf = ent_sum > ENT_IMAX;

    assign sum_res     = sat_add(r_sum, r_pending, r_term_neg);
    assign key_is_term = r_key_op inside {OP_MUL, OP_DIV};
    assign key_term    = (r_key_op == OP_MUL) ? TOP_MUL : TOP_DIV;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_entry     = r_entry;
        n_sum       = r_sum;
        n_pending   = r_pending;
        n_term_op   = r_term_op;
        n_term_neg  = r_term_neg;
        n_finished  = r_finished;
        n_dbz       = r_dbz;
        n_ovf       = r_ovf;
        n_key_op    = r_key_op;
        n_md_start  = 1'b0;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key_op = i_in_data.opcode;
                    if (i_in_data.opcode == OP_CLEAR) begin
                        n_entry    = '0;
                        n_sum      = '0;
                        n_pending  = '0;
                        n_term_op  = TOP_NONE;
                        n_term_neg = 1'b0;
                        n_finished = 1'b0;
                        n_dbz      = 1'b0;
                        n_ovf      = 1'b0;
                    end else if (!r_finished) begin
                        case (i_in_data.opcode)
                            OP_DIGIT: begin
                                if (ent_ovf) begin
                                    n_entry = POS_LIM;
                                    n_ovf   = 1'b1;
                                end else begin
                                    n_entry = VALUE_BITS'(ent_sum) << FRAC_BITS;
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQUALS: begin
                                if (r_term_op == TOP_MUL || r_term_op == TOP_DIV) begin
                                    n_md_start = 1'b1;
                                    n_state    = S_MULDIV;
                                end else begin
                                    n_pending = r_entry;
                                    n_entry   = '0;
                                    n_term_op = TOP_NONE;
                                    if (i_in_data.opcode == OP_MUL) begin
                                        n_term_op = TOP_MUL;
                                    end else if (i_in_data.opcode == OP_DIV) begin
                                        n_term_op = TOP_DIV;
                                    end else begin
                                        n_state = S_SUM;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_MULDIV: begin
                if (md_rsp.done) begin
                    n_pending = md_rsp.value;
                    n_dbz     = r_dbz | md_rsp.div_by_zero;
                    n_ovf     = r_ovf | md_rsp.overflow;
                    n_entry   = '0;
                    if (key_is_term) begin
                        n_term_op = key_term;
                        n_state   = S_IDLE;
                    end else begin
                        n_term_op = TOP_NONE;
                        n_state   = S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (r_key_op != OP_EQUALS || !r_out_valid || i_out_ready) begin
                    n_sum      = sum_res.value;
                    n_ovf      = r_ovf | sum_res.ovf;
                    n_pending  = '0;
                    n_term_neg = (r_key_op == OP_SUB);
                    n_state    = S_IDLE;
                    if (r_key_op == OP_EQUALS) begin
                        n_finished             = 1'b1;
                        n_out_valid            = 1'b1;
                        n_out_data.value       = sum_res.value;
                        n_out_data.div_by_zero = r_dbz;
                        n_out_data.overflow    = r_ovf | sum_res.ovf;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entry     <= '0;
            r_sum       <= '0;
            r_pending   <= '0;
            r_term_op   <= TOP_NONE;
            r_term_neg  <= 1'b0;
            r_finished  <= 1'b0;
            r_dbz       <= 1'b0;
            r_ovf       <= 1'b0;
            r_md_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_entry     <= n_entry;
            r_sum       <= n_sum;
            r_pending   <= n_pending;
            r_term_op   <= n_term_op;
            r_term_neg  <= n_term_neg;
            r_finished  <= n_finished;
            r_dbz       <= n_dbz;
            r_ovf       <= n_ovf;
            r_md_start  <= n_md_start;
            r_out_valid <= n_out_valid;
        end
        r_key_op   <= n_key_op;
        r_out_data <= n_out_data;
    end

    `KEE_ASSERT(a_entry_positive, !r_entry[VALUE_BITS-1], "Entry value became negative.")
    `KEE_ASSERT_IMP(a_finished_clean, r_finished,
        r_term_op == TOP_NONE && r_entry == '0 && r_pending == '0,
        "Term state left over after equals.")
    `KEE_ASSERT_IMP(a_result_after_equals, $rose(o_out_valid), r_finished,
        "Result item raised without equals.")

endmodule

### sv/kee_muldiv.sv
// ----------------------------------------------------------------------------
// Serial fixed-point multiply and divide unit
// Shift-and-add multiplier and restoring divider, one bit per cycle, with
// sign-magnitude handling and saturation of the fixed-point result.
// ----------------------------------------------------------------------------
`include "keypad_expression_evaluator_defines.svh"

module kee_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  kee_pkg::t_md_req i_req,
    output kee_pkg::t_md_rsp o_rsp
);
    import kee_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIN} t_md_state;

    t_md_state                 r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_neg, n_neg;
    logic                      r_is_div, n_is_div;
    logic                      r_dbz, n_dbz;
    logic [VALUE_BITS-1:0]     r_opnd, n_opnd;
    logic [2*VALUE_BITS-1:0]   r_prod, n_prod;
    logic [VALUE_BITS-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]          r_quo, n_quo;

    logic [VALUE_BITS-1:0]     mag_a, mag_b;
    logic [VALUE_BITS:0]       mul_sum;
    logic [VALUE_BITS:0]       div_trial, div_rem;
    logic                      div_ge;
    logic [WIDE_W-1:0]         mag_wide, lim_wide;
    logic                      sat;
    logic [VALUE_BITS-1:0]     mag_sel, res_value;

    assign mag_a = i_req.a[VALUE_BITS-1] ? (~i_req.a + VALUE_BITS'(1)) : i_req.a;
    assign mag_b = i_req.b[VALUE_BITS-1] ? (~i_req.b + VALUE_BITS'(1)) : i_req.b;

    assign mul_sum = {1'b0, r_prod[2*VALUE_BITS-1:VALUE_BITS]}
                   + (r_prod[0] ? {1'b0, r_opnd} : '0);

    assign div_trial = {r_rem, r_quo[DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_opnd};
    assign div_rem   = div_ge ? (div_trial - {1'b0, r_opnd}) : div_trial;

    assign mag_wide  = r_is_div ? WIDE_W'(r_quo) : WIDE_W'(r_prod >> FRAC_BITS);
    assign lim_wide  = r_neg ? WIDE_W'(NEG_LIM) : WIDE_W'(POS_LIM);
    assign sat       = mag_wide > lim_wide;
    assign mag_sel   = sat ? lim_wide[VALUE_BITS-1:0] : mag_wide[VALUE_BITS-1:0];
    assign res_value = r_neg ? (~mag_sel + VALUE_BITS'(1)) : mag_sel;

    assign o_rsp.done        = (r_state == M_FIN);
    assign o_rsp.value       = r_dbz ? '0 : res_value;
    assign o_rsp.overflow    = !r_dbz && sat;
    assign o_rsp.div_by_zero = r_dbz;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_is_div = r_is_div;
        n_dbz    = r_dbz;
        n_opnd   = r_opnd;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_quo    = r_quo;
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_neg    = i_req.a[VALUE_BITS-1] ^ i_req.b[VALUE_BITS-1];
                    n_is_div = i_req.is_div;
                    n_dbz    = 1'b0;
                    if (i_req.is_div) begin
                        n_opnd = mag_b;
                        n_rem  = '0;
                        n_quo  = DIV_W'(mag_a) << FRAC_BITS;
                        n_cnt  = CNT_W'(DIV_W);
                        if (mag_b == '0) begin
                            n_dbz   = 1'b1;
                            n_state = M_FIN;
                        end else begin
                            n_state = M_DIV;
                        end
                    end else begin
                        n_opnd  = mag_a;
                        n_prod  = {{VALUE_BITS{1'b0}}, mag_b};
                        n_cnt   = CNT_W'(VALUE_BITS);
                        n_state = M_MUL;
                    end
                end
            end
            M_MUL: begin
                n_prod = {mul_sum, r_prod[VALUE_BITS-1:1]};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = M_FIN;
                end
            end
            M_DIV: begin
                n_rem = div_rem[VALUE_BITS-1:0];
                n_quo = {r_quo[DIV_W-2:0], div_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = M_FIN;
                end
            end
            M_FIN: begin
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
            r_dbz   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dbz   <= n_dbz;
        end
        r_neg    <= n_neg;
        r_is_div <= n_is_div;
        r_opnd   <= n_opnd;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
    end

    `KEE_ASSERT(a_done_one_cycle, o_rsp.done |=> !o_rsp.done, "Done held longer than one cycle.")
    `KEE_ASSERT_IMP(a_start_when_idle, i_start, r_state == M_IDLE, "Start while the unit is busy.")
    `KEE_ASSERT_IMP(a_busy_count, r_state == M_MUL || r_state == M_DIV, r_cnt != '0,
        "Step counter empty while busy.")
    `KEE_ASSERT_IMP(a_dbz_result, o_rsp.done && o_rsp.div_by_zero,
        o_rsp.value == '0 && !o_rsp.overflow, "Zero divisor gave a nonzero result.")

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad expression evaluator testbench
// Feeds key items and checks every equals result against a behavioral model.
// ----------------------------------------------------------------------------
// A short directed sequence covers empty operands, divide by zero, keys after
// equals, the unused opcode and entry saturation. Random expressions with
// random operators and digits follow, with noise keys mixed in. Both channels
// idle at random, and once the output side holds off long enough for the
// block to stall its input.
module testbench;
    import kee_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_RESERVED  = 3'd7;
    localparam logic [1:0]          TERM_NONE    = 2'd0;
    localparam logic [1:0]          TERM_MUL     = 2'd1;
    localparam logic [1:0]          TERM_DIV     = 2'd2;
    localparam int unsigned         DECIMAL_BASE = 10;
    localparam int                  RANDOM_KEYS  = 550;
    localparam int                  HOLD_CYCLES  = 1500;
    localparam int                  DRAIN_CYCLES = 150;
    localparam int                  TIMEOUT_NS   = 10_000_000;

    typedef logic [VALUE_BITS-1:0] fix_t;

    class calc_checker;
        fix_t         entry_val;
        fix_t         sum_val;
        fix_t         term_val;
        logic [1:0]   term_op;
        bit           term_neg;
        bit           done_flag;
        bit           dz_flag;
        bit           ovf_flag;
        t_result_item awaited[$];
        int           failures;

        function new();
            clear_state();
            failures = 0;
        endfunction

        function void clear_state();
            entry_val = '0;
            sum_val   = '0;
            term_val  = '0;
            term_op   = TERM_NONE;
            term_neg  = 1'b0;
            done_flag = 1'b0;
            dz_flag   = 1'b0;
            ovf_flag  = 1'b0;
        endfunction

        function void split_value(input fix_t p, output bit neg, output logic [63:0] mag);
            fix_t flipped;
            flipped = -p;
            neg = p[VALUE_BITS-1];
            mag = neg ? 64'(flipped) : 64'(p);
        endfunction

        function fix_t saturate(bit neg, logic [63:0] mag, bit big);
            logic [63:0] lim;
            lim = neg ? 64'(NEG_LIM) : 64'(POS_LIM);
            if (big || mag > lim) begin
                mag = lim;
                ovf_flag = 1'b1;
            end
            return neg ? fix_t'(64'd0 - mag) : fix_t'(mag);
        endfunction

        function fix_t signed_sum(bit na, logic [63:0] ma, bit nb, logic [63:0] mb);
            logic [63:0] s;
            s = ma + mb;
            if (na == nb) return saturate(na, s, s < ma);
            if (ma >= mb) return saturate(na, ma - mb, 1'b0);
            return saturate(nb, mb - ma, 1'b0);
        endfunction

        function fix_t product(fix_t a, fix_t b);
            bit           na, nb;
            logic [63:0]  ma, mb;
            logic [127:0] full;
            split_value(a, na, ma);
            split_value(b, nb, mb);
            full = (128'(ma) * 128'(mb)) >> FRAC_BITS;
            return saturate(na ^ nb, full[63:0], |full[127:64]);
        endfunction

        function fix_t quotient(fix_t a, fix_t b);
            bit           na, nb;
            logic [63:0]  ma, mb;
            logic [127:0] full;
            split_value(a, na, ma);
            split_value(b, nb, mb);
            if (mb == 0) begin
                dz_flag = 1'b1;
                return '0;
            end
            full = (128'(ma) << FRAC_BITS) / 128'(mb);
            return saturate(na ^ nb, full[63:0], |full[127:64]);
        endfunction

        function void close_term();
            case (term_op)
                TERM_MUL: term_val = product(term_val, entry_val);
                TERM_DIV: term_val = quotient(term_val, entry_val);
                default:  term_val = entry_val;
            endcase
            entry_val = '0;
            term_op   = TERM_NONE;
        endfunction

        function void close_sum(bit next_neg);
            bit          ns, np;
            logic [63:0] ms, mp;
            split_value(sum_val, ns, ms);
            split_value(term_val, np, mp);
            if (term_neg) np = !np;
            sum_val  = signed_sum(ns, ms, np, mp);
            term_val = '0;
            term_neg = next_neg;
        endfunction

        function void add_digit(logic [3:0] d);
            logic [63:0] imax, whole;
            imax  = 64'(POS_LIM) >> FRAC_BITS;
            whole = 64'(entry_val) >> FRAC_BITS;
            if (64'(d) > imax || whole > (imax - 64'(d)) / DECIMAL_BASE) begin
                entry_val = POS_LIM;
                ovf_flag  = 1'b1;
            end else begin
                entry_val = fix_t'((whole * DECIMAL_BASE + 64'(d)) << FRAC_BITS);
            end
        endfunction

        // Returns 1 when the key has an effect on the evaluator.
        function bit note_key(t_key_item k);
            t_result_item want;
            if (k.opcode == OP_CLEAR) begin
                clear_state();
                return 1'b1;
            end
            if (done_flag) return 1'b0;
            case (k.opcode)
                OP_DIGIT: add_digit(k.digit);
                OP_ADD, OP_SUB: begin
                    close_term();
                    close_sum(k.opcode == OP_SUB);
                end
                OP_MUL, OP_DIV: begin
                    close_term();
                    term_op = (k.opcode == OP_MUL) ? TERM_MUL : TERM_DIV;
                end
                OP_EQUALS: begin
                    close_term();
                    close_sum(1'b0);
                    done_flag         = 1'b1;
                    want.value        = sum_val;
                    want.div_by_zero  = dz_flag;
                    want.overflow     = ovf_flag;
                    awaited.push_back(want);
                end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void check_result(t_result_item got);
            t_result_item want;
            if (awaited.size() == 0) begin
                $error("unexpected result item, value %0d", got.value);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.value !== want.value) begin
                $error("value: expected %0d, actual %0d", want.value, got.value);
                failures++;
            end
            if (got.div_by_zero !== want.div_by_zero) begin
                $error("div_by_zero: expected %0b, actual %0b", want.div_by_zero,
                       got.div_by_zero);
                failures++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                failures++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_ready;
    t_key_item    i_in_data;
    logic         o_out_valid;
    logic         i_out_ready;
    t_result_item o_out_data;

    calc_checker chk = new();
    bit          steady = 1'b0;
    bit          hold_out = 1'b0;
    int          keys_effective = 0;

    keypad_expression_evaluator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function bit take_break();
        return !steady && ($urandom_range(99) < 31);
    endfunction

    task automatic send_key(input t_key_item k);
        while (take_break()) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= k;
        do @(posedge i_clk); while (!o_in_ready);
        if (chk.note_key(k)) keys_effective++;
    endtask

    task automatic press(input logic [OPCODE_W-1:0] op, input logic [DIGIT_W-1:0] d);
        t_key_item k;
        k.opcode = op;
        k.digit  = d;
        send_key(k);
    endtask

    task automatic press_noise();
        press(3'($urandom_range(7)), 4'($urandom_range(15)));
    endtask

    task automatic send_operand();
        int n;
        n = ($urandom_range(99) < 8) ? $urandom_range(12, 10) : $urandom_range(3);
        repeat (n) begin
            if ($urandom_range(99) < 4) press_noise();
            press(OP_DIGIT, ($urandom_range(99) < 85) ? 4'($urandom_range(9))
                                                      : 4'($urandom_range(15, 10)));
        end
    endtask

    task automatic send_expression();
        int terms;
        terms = $urandom_range(5, 1);
        for (int t = 0; t < terms; t++) begin
            send_operand();
            if (t < terms - 1) begin
                press(3'($urandom_range(int'(OP_DIV), int'(OP_ADD))), 4'($urandom_range(15)));
                if ($urandom_range(99) < 4) press_noise();
            end
        end
        if ($urandom_range(99) < 90) press(OP_EQUALS, 4'($urandom_range(15)));
        if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(3, 1)) begin
                press(3'($urandom_range(int'(OP_EQUALS), int'(OP_DIGIT))),
                      4'($urandom_range(15)));
            end
        end
        press(OP_CLEAR, 4'($urandom_range(15)));
    endtask

    // Output side: random stalls, plus one long hold-off while keys keep coming.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= !hold_out && !take_break();
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) chk.check_result(o_out_data);
        end
    end

    initial begin
        wait (keys_effective >= 150);
        hold_out = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_out = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("keypad_expression_evaluator test failed");
        $finish;
    end

    initial begin
        int expressions;
        int base;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        press(OP_EQUALS, 4'd0);
        press(OP_CLEAR, 4'd0);
        press(OP_SUB, 4'd0);
        press(OP_DIGIT, 4'd15);
        press(OP_MUL, 4'd0);
        press(OP_DIGIT, 4'd7);
        press(OP_DIV, 4'd0);
        press(OP_SUB, 4'd0);
        press(OP_DIGIT, 4'd3);
        press(OP_EQUALS, 4'd0);
        press(OP_DIGIT, 4'd5);
        press(OP_RESERVED, 4'd15);
        press(OP_CLEAR, 4'd0);
        repeat (10) press(OP_DIGIT, 4'd9);
        press(OP_MUL, 4'd0);
        press(OP_DIGIT, 4'd9);
        press(OP_DIGIT, 4'd9);
        press(OP_EQUALS, 4'd0);
        press(OP_CLEAR, 4'd0);

        base = keys_effective;
        expressions = 0;
        while (keys_effective < base + RANDOM_KEYS) begin
            steady = (expressions >= 20 && expressions < 35);
            send_expression();
            expressions++;
        end
        steady = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (chk.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk.failures == 0) begin
            $display("keypad_expression_evaluator test passed");
        end else begin
            $display("keypad_expression_evaluator test failed");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+sv
sv/kee_pkg.sv
sv/kee_muldiv.sv
sv/keypad_expression_evaluator.sv
bench/testbench.sv
